>>> design/bcpa_pkg.sv
// ----------------------------------------------------------------------------
// bcpa_pkg
// types, constants and command codes shared by the point adder modules
// ----------------------------------------------------------------------------
package bcpa_pkg;

  localparam int MaxFieldBits = 43;
  localparam int DegW = 6;
  localparam int CfgIdxW = 2;

  typedef logic [MaxFieldBits-1:0] fe_t;

  localparam logic [CfgIdxW-1:0] CFG_DEGREE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MODULUS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CURVE_A = 2'd2;

  typedef struct packed {
    fe_t  p_x;
    fe_t  p_y;
    logic p_inf;
    fe_t  q_x;
    fe_t  q_y;
    logic q_inf;
  } in_word_t;

  typedef struct packed {
    fe_t  r_x;
    fe_t  r_y;
    logic r_inf;
  } out_word_t;

  // register file selects
  typedef enum logic [3:0] {
    R_PX, R_PY, R_LAM, R_X3, R_Y3, R_B, R_T, R_U, R_DY
  } reg_sel_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // latch and mask inputs, form dx and dy
    OP_CLASS,    // special case results, inversion operand into u and b
    OP_COPY,     // t = b
    OP_MUL,      // start multiply src_a * src_b into dst
    OP_LAM_DBL,  // lam = px ^ t
    OP_X3,       // x3 = t ^ lam ^ dx ^ a
    OP_Y3_DBL,   // y3 = y3 ^ t
    OP_Y3_ADD    // y3 = y3 ^ x3 ^ py
  } op_t;

  typedef struct packed {
    op_t      op;
    reg_sel_t src_a;
    reg_sel_t src_b;
    reg_sel_t dst;
    logic     lam_inc;   // use lam ^ 1 as first operand
    logic     px_xor_x3; // use px ^ x3 as second operand
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic p_inf;
    logic q_inf;
    logic same_x;
    logic sum_inf;
    logic [DegW-1:0] deg;
  } dp_stat_t;

endpackage

>>> design/bcpa_mul.sv
// ----------------------------------------------------------------------------
// bcpa_mul
// bit-serial carry-less multiplier with interleaved modular reduction
// ----------------------------------------------------------------------------
module bcpa_mul
  import bcpa_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  fe_t             a,
  input  fe_t             b,
  input  logic [DegW-1:0] deg,
  input  fe_t             modulus,
  input  fe_t             mask,
  output logic            done,
  output fe_t             result
);

  fe_t acc;
  fe_t opa;
  fe_t opb;
  logic [DegW-1:0] cnt;
  logic busy;

  // msb-first: acc = acc*x mod f, then add a if bit set
  fe_t  shifted;
  logic top;
  fe_t  acc_next;

  always_comb begin
    top = |(acc & ~(mask >> 1));
    shifted = (acc << 1) & mask;
    if (top) begin
      shifted = shifted ^ modulus;
    end
    acc_next = opb[MaxFieldBits-1] ? (shifted ^ opa) : shifted;
  end

  // opb is aligned so that bit n-1 sits at the top
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      acc  <= '0;
      opa  <= '0;
      opb  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      acc  <= '0;
      opa  <= a;
      opb  <= b << (6'(MaxFieldBits) - deg);
      cnt  <= deg;
    end else if (busy) begin
      acc  <= acc_next;
      opb  <= opb << 1;
      cnt  <= cnt - 1'b1;
      busy <= (cnt != 6'd1);
      done <= (cnt == 6'd1);
    end else begin
      done <= 1'b0;
    end
  end

  assign result = acc;

endmodule

>>> design/bcpa_datapath.sv
// ----------------------------------------------------------------------------
// bcpa_datapath
// operand registers, field configuration and the shared multiplier
// ----------------------------------------------------------------------------
module bcpa_datapath
  import bcpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  fe_t                cfg_data,
  input  in_word_t           in_word,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output out_word_t          res
);

  logic [DegW-1:0] field_degree;
  fe_t  modulus_low;
  logic curve_a;

  logic [DegW-1:0] deg;
  fe_t  mask;
  fe_t  fmod;

  fe_t px, py, qx, qy, dx, dy, u, b, t, lam, x3, y3;
  logic pinf, qinf, rinf;
  logic same_x, sum_inf;

  always_comb begin
    deg = field_degree;
    if (deg < 6'd2) begin
      deg = 6'd2;
    end
    if (deg > 6'(MaxFieldBits)) begin
      deg = 6'(MaxFieldBits);
    end
    mask = fe_t'(({1'b0, {MaxFieldBits{1'b1}}} >> (MaxFieldBits - int'(deg))));
    fmod = modulus_low & mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_degree <= 6'd43;
      modulus_low  <= fe_t'(89);
      curve_a      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DEGREE:  field_degree <= cfg_data[DegW-1:0];
        CFG_MODULUS: modulus_low  <= cfg_data;
        CFG_CURVE_A: curve_a      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fe_t opa, opb, mres;
  logic mdone;

  always_comb begin
    case (cmd.src_a)
      R_PX:    opa = px;
      R_PY:    opa = py;
      R_LAM:   opa = lam;
      R_X3:    opa = x3;
      R_Y3:    opa = y3;
      R_B:     opa = b;
      R_T:     opa = t;
      R_U:     opa = u;
      R_DY:    opa = dy;
      default: opa = '0;
    endcase
    case (cmd.src_b)
      R_PX:    opb = px;
      R_PY:    opb = py;
      R_LAM:   opb = lam;
      R_X3:    opb = x3;
      R_Y3:    opb = y3;
      R_B:     opb = b;
      R_T:     opb = t;
      R_U:     opb = u;
      R_DY:    opb = dy;
      default: opb = '0;
    endcase
    if (cmd.lam_inc) begin
      opa = lam ^ fe_t'(1);
    end
    if (cmd.px_xor_x3) begin
      opb = px ^ x3;
    end
  end

  bcpa_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.op == OP_MUL),
    .a       (opa),
    .b       (opb),
    .deg     (deg),
    .modulus (fmod),
    .mask    (mask),
    .done    (mdone),
    .result  (mres)
  );

  reg_sel_t mdst;

  always_comb begin
    same_x  = (dx == '0);
    sum_inf = same_x && (dy == px || px == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mdst <= R_T;
      px   <= '0;
      py   <= '0;
      qx   <= '0;
      qy   <= '0;
      dx   <= '0;
      dy   <= '0;
      u    <= '0;
      b    <= '0;
      t    <= '0;
      lam  <= '0;
      x3   <= '0;
      y3   <= '0;
      pinf <= 1'b0;
      qinf <= 1'b0;
      rinf <= 1'b0;
    end else begin
      if (cmd.op == OP_MUL) begin
        mdst <= cmd.dst;
      end
      if (mdone) begin
        case (mdst)
          R_LAM:   lam <= mres;
          R_Y3:    y3  <= mres;
          R_B:     b   <= mres;
          default: t   <= mres;
        endcase
      end else begin
        case (cmd.op)
          OP_LOAD: begin
            px   <= in_word.p_x & mask;
            py   <= in_word.p_y & mask;
            qx   <= in_word.q_x & mask;
            qy   <= in_word.q_y & mask;
            pinf <= in_word.p_inf;
            qinf <= in_word.q_inf;
            dx   <= (in_word.p_x ^ in_word.q_x) & mask;
            dy   <= (in_word.p_y ^ in_word.q_y) & mask;
          end
          OP_CLASS: begin
            if (pinf) begin
              x3   <= qinf ? '0 : qx;
              y3   <= qinf ? '0 : qy;
              rinf <= qinf;
            end else if (qinf) begin
              x3   <= px;
              y3   <= py;
              rinf <= 1'b0;
            end else if (sum_inf) begin
              x3   <= '0;
              y3   <= '0;
              rinf <= 1'b1;
            end else begin
              rinf <= 1'b0;
              u    <= same_x ? px : dx;
              b    <= same_x ? px : dx;
            end
          end
          OP_COPY:    t   <= b;
          OP_LAM_DBL: lam <= px ^ t;
          OP_X3:      x3  <= t ^ lam ^ dx ^ fe_t'(curve_a);
          OP_Y3_DBL:  y3  <= y3 ^ t;
          OP_Y3_ADD:  y3  <= y3 ^ x3 ^ py;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    stat.mul_done = mdone;
    stat.p_inf    = pinf;
    stat.q_inf    = qinf;
    stat.same_x   = same_x;
    stat.sum_inf  = sum_inf;
    stat.deg      = deg;
  end

  assign res.r_x   = x3;
  assign res.r_y   = y3;
  assign res.r_inf = rinf;

endmodule

>>> design/bcpa_ctrl.sv
// ----------------------------------------------------------------------------
// bcpa_ctrl
// sequencer for case selection, inversion chain and point formulas
// ----------------------------------------------------------------------------
module bcpa_ctrl
  import bcpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  // inversion of u: b holds u^(2^e-1); squarings run in t, the final squaring in b
  typedef enum logic [4:0] {
    S_IDLE, S_CLASS, S_SCAN, S_SQ, S_SQ_WAIT, S_MB, S_MB_WAIT, S_BSQ, S_BSQ_WAIT,
    S_BMUL, S_BMUL_WAIT, S_NEXT, S_FIN, S_FIN_WAIT, S_LAM, S_LAM_WAIT, S_LAM_FIX,
    S_X3SQ, S_X3SQ_WAIT, S_X3, S_Y3A, S_Y3A_WAIT, S_Y3B, S_Y3B_WAIT, S_Y3_FIX,
    S_DONE
  } state_t;

  state_t state;
  logic [DegW-1:0] k;
  logic [DegW-1:0] e;
  logic [DegW-1:0] sq_cnt;
  logic [2:0] bitpos;
  logic started;
  logic dbl;

  dp_cmd_t c;

  always_comb begin
    c = '{op: OP_NONE, src_a: R_T, src_b: R_T, dst: R_T, lam_inc: 1'b0,
          px_xor_x3: 1'b0};
    case (state)
      S_IDLE:  if (in_valid) c.op = OP_LOAD;
      S_CLASS: c.op = OP_CLASS;
      S_SCAN:  if (started) c.op = OP_COPY;
      S_SQ: begin
        c.op = OP_MUL; c.src_a = R_T; c.src_b = R_T; c.dst = R_T;
      end
      S_MB: begin
        c.op = OP_MUL; c.src_a = R_T; c.src_b = R_B; c.dst = R_B;
      end
      S_BSQ: begin
        c.op = OP_MUL; c.src_a = R_B; c.src_b = R_B; c.dst = R_T;
      end
      S_BMUL: begin
        c.op = OP_MUL; c.src_a = R_T; c.src_b = R_U; c.dst = R_B;
      end
      S_FIN: begin
        c.op = OP_MUL; c.src_a = R_B; c.src_b = R_B; c.dst = R_B;
      end
      S_LAM: begin
        c.op = OP_MUL; c.src_a = dbl ? R_PY : R_DY; c.src_b = R_B;
        c.dst = dbl ? R_T : R_LAM;
      end
      S_LAM_FIX: if (dbl) c.op = OP_LAM_DBL;
      S_X3SQ: begin
        c.op = OP_MUL; c.src_a = R_LAM; c.src_b = R_LAM; c.dst = R_T;
      end
      S_X3: c.op = OP_X3;
      S_Y3A: begin
        // doubling: (lam^1)*x3, addition: lam*(px^x3)
        c.op = OP_MUL; c.src_a = R_LAM; c.src_b = R_X3; c.dst = R_Y3;
        c.lam_inc = dbl; c.px_xor_x3 = !dbl;
      end
      S_Y3B: begin
        c.op = OP_MUL; c.src_a = R_PX; c.src_b = R_PX; c.dst = R_T;
      end
      S_Y3_FIX: c.op = dbl ? OP_Y3_DBL : OP_Y3_ADD;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
      e         <= '0;
      sq_cnt    <= '0;
      bitpos    <= '0;
      started   <= 1'b0;
      dbl       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_CLASS;
        S_CLASS: begin
          k       <= stat.deg - 1'b1;
          bitpos  <= 3'd5;
          started <= 1'b0;
          dbl     <= stat.same_x;
          if (stat.p_inf || stat.q_inf || stat.sum_inf) begin
            state     <= S_DONE;
            out_valid <= 1'b1;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!started) begin
            // skip to the leading one of k
            if (k[bitpos]) begin
              started <= 1'b1;
              e       <= 6'd1;
            end
            if (bitpos == 3'd0) begin
              state <= S_FIN;
            end else begin
              bitpos <= bitpos - 1'b1;
            end
          end else begin
            sq_cnt <= e;
            state  <= S_SQ;
          end
        end
        S_SQ: state <= S_SQ_WAIT;
        S_SQ_WAIT: if (stat.mul_done) begin
          if (sq_cnt == 6'd1) begin
            state <= S_MB;
          end else begin
            sq_cnt <= sq_cnt - 1'b1;
            state  <= S_SQ;
          end
        end
        S_MB: state <= S_MB_WAIT;
        S_MB_WAIT: if (stat.mul_done) begin
          e     <= {e[DegW-2:0], 1'b0};
          state <= k[bitpos] ? S_BSQ : S_NEXT;
        end
        S_BSQ: state <= S_BSQ_WAIT;
        S_BSQ_WAIT: if (stat.mul_done) state <= S_BMUL;
        S_BMUL: state <= S_BMUL_WAIT;
        S_BMUL_WAIT: if (stat.mul_done) begin
          e     <= e + 1'b1;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (bitpos == 3'd0) begin
            state <= S_FIN;
          end else begin
            bitpos <= bitpos - 1'b1;
            state  <= S_SCAN;
          end
        end
        S_FIN: state <= S_FIN_WAIT;
        S_FIN_WAIT: if (stat.mul_done) state <= S_LAM;
        S_LAM: state <= S_LAM_WAIT;
        S_LAM_WAIT: if (stat.mul_done) state <= S_LAM_FIX;
        S_LAM_FIX: state <= S_X3SQ;
        S_X3SQ: state <= S_X3SQ_WAIT;
        S_X3SQ_WAIT: if (stat.mul_done) state <= S_X3;
        S_X3: state <= S_Y3A;
        S_Y3A: state <= S_Y3A_WAIT;
        S_Y3A_WAIT: if (stat.mul_done) state <= dbl ? S_Y3B : S_Y3_FIX;
        S_Y3B: state <= S_Y3B_WAIT;
        S_Y3B_WAIT: if (stat.mul_done) state <= S_Y3_FIX;
        S_Y3_FIX: begin
          state     <= S_DONE;
          out_valid <= 1'b1;
        end
        S_DONE: if (out_ready) begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign cmd      = c;

endmodule

>>> design/binary_curve_point_add_core.sv
// a finite sum needs n-1 squarings and up to 2*log2(n) products on the bit-serial
// multiplier for the inversion, then three or four formula products
// infinite operand or infinite sum: the result is set in S_CLASS, which goes
// straight to S_DONE without the inversion
// one word in flight at a time; synchronous active-high reset sets n=43, modulus 89, a=0
// ----------------------------------------------------------------------------
// binary_curve_point_add_core
// affine point addition on a binary curve over a configurable GF(2^n)
// ----------------------------------------------------------------------------
module binary_curve_point_add_core
  import bcpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  fe_t                cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bcpa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bcpa_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_word  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .res      (out_data)
  );

endmodule
